// File: sv/jacd_pkg.sv
`default_nettype none

package jacd_pkg;

	// Parameter defaults
	localparam int CALIB_COUNT_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 12;

	// Fixed field widths
	localparam int SAMPLE_W  = 12;
	localparam int S_DATA_W  = 16;
	localparam int S_USER_W  = 2;
	localparam int DZ_W      = 16;
	localparam int LIM_W     = 12;
	localparam int POS_W     = 16;
	localparam int M_USER_W  = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	// Divisor width of the shared divider: good-read counts, spans and 1.0 - dead zone
	localparam int DIV_DW = DZ_W + 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DZ_FRAC      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LIMIT = CFG_IDX_W'(1);

	// Configuration reset values
	localparam logic [DZ_W-1:0]  DZ_RESET  = DZ_W'(16384);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1023);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CDIV,
		ST_DIV1,
		ST_DIV2,
		ST_OUT
	} jacd_state_t;

endpackage

`default_nettype wire

// File: sv/jacd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend low bits
// shift out MSB first; the starting remainder must be below the divisor.
module jacd_div import jacd_pkg::*; #(
	parameter int DW = DIV_DW,
	parameter int LW = DIV_DW
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DW-1:0]              r0,
	input  wire logic [LW-1:0]              lo,
	input  wire logic [DW-1:0]              dvs,
	input  wire logic [$clog2(LW+1)-1:0]    steps,
	output logic                            done,
	output logic [LW-1:0]                   quo
);

	localparam int STW = $clog2(LW + 1);

	logic            busy_q;
	logic            done_q;
	logic [STW-1:0]  cnt_q;
	logic [DW-1:0]   rem_q;
	logic [LW-1:0]   lo_q;
	logic [LW-1:0]   quo_q;
	logic [DW-1:0]   dvs_q;

	logic [DW:0]     trial;
	logic [DW:0]     sub;
	logic            ge;
	logic [DW-1:0]   rem_nx;

	// Shift in the next dividend bit and try to subtract
	always_comb begin
		trial  = {rem_q, lo_q[LW-1]};
		sub    = trial - {1'b0, dvs_q};
		ge     = trial >= {1'b0, dvs_q};
		rem_nx = ge ? sub[DW-1:0] : trial[DW-1:0];
	end

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - STW'(1);
			done_q <= (cnt_q == STW'(1));
			if (cnt_q == STW'(1)) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= r0;
			lo_q  <= lo;
			dvs_q <= dvs;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[LW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: sv/joystick_axis_calibrate_deadzone.sv
// A calibration attempt goes from ST_EVAL to ST_OUT; an axis's last attempt with good reads
// also runs the center division in ST_CDIV, and a deflection past the dead zone runs two
// divisions (ST_DIV1, ST_DIV2), while one inside the dead zone runs only ST_DIV1.
// One transaction at a time: s_tready is high only in ST_IDLE, so the next input is taken
// only once the result has registered, and a result stall holds it back.
// Reset (arst_n low): mid-scale centers, zero counts, dead zone 0.25, offset limit 1023.
`default_nettype none

module joystick_axis_calibrate_deadzone import jacd_pkg::*; #(
	parameter int CALIB_COUNT = CALIB_COUNT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tdata: sample[11:0], zero fill
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	// tuser: axis, sample_ok
	input  wire logic [S_USER_W-1:0]   s_tuser,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata: position[15:0]
	output logic [POS_W-1:0]           m_tdata,
	// tuser: axis_out, ready_res, center_fallback
	output logic [M_USER_W-1:0]        m_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(CALIB_COUNT + 1);
	localparam int SUMW = SB + CW;
	localparam int DW   = DIV_DW;
	localparam int LW   = (SUMW > DW) ? SUMW : DW;
	localparam int STW  = $clog2(LW + 1);
	localparam int CMPW = (SB > LIM_W) ? SB : LIM_W;

	localparam logic [SB-1:0] ADC_MAX = {SB{1'b1}};
	localparam logic [SB-1:0] ADC_MID = {1'b0, {(SB-1){1'b1}}};
	localparam logic [CW-1:0] CAL_N   = CW'(CALIB_COUNT);

	jacd_state_t state_q, state_nx;

	// Configuration
	logic [DZ_W-1:0]  dz_q;
	logic [LIM_W-1:0] lim_q;

	// Per-axis calibration state
	logic [SB-1:0]    center_q [2];
	logic [SUMW-1:0]  sum_q    [2];
	logic [CW-1:0]    att_q    [2];
	logic [CW-1:0]    good_q   [2];
	logic             fb_q     [2];

	// Item in flight
	logic             axis_q;
	logic [SB-1:0]    raw_q;
	logic             ok_q;
	logic             neg_q;
	logic [POS_W-1:0] pos_q;

	// Output register
	logic                  m_valid_q;
	logic [POS_W-1:0]      m_data_q;
	logic [M_USER_W-1:0]   m_user_q;

	// Datapath values
	logic             done0, done1, done_a, both_done;
	logic [CW-1:0]    att_new, good_new;
	logic [SUMW-1:0]  sum_new;
	logic             last_att;
	logic [SB-1:0]    center_a;
	logic             neg;
	logic [SB-1:0]    span, diff;
	logic [DW-1:0]    mag;
	logic             below_dz;
	logic [DW-1:0]    md;
	logic [SB-1:0]    cnew, ctr_dist;
	logic             in_limit;
	logic [DZ_W-1:0]  scaled;
	logic             out_free;

	// Divider interface
	logic             div_start;
	logic [DW-1:0]    div_r0;
	logic [LW-1:0]    div_lo;
	logic [DW-1:0]    div_dvs;
	logic [STW-1:0]   div_steps;
	logic             div_done;
	logic [LW-1:0]    div_quo;

	jacd_div #(
		.DW (DW),
		.LW (LW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.r0     (div_r0),
		.lo     (div_lo),
		.dvs    (div_dvs),
		.steps  (div_steps),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Decode calibration progress and the deflection operands
	always_comb begin
		done0     = att_q[0] >= CAL_N;
		done1     = att_q[1] >= CAL_N;
		done_a    = att_q[axis_q] >= CAL_N;
		both_done = done0 && done1;
		att_new   = att_q[axis_q] + CW'(1);
		good_new  = good_q[axis_q] + CW'(ok_q);
		sum_new   = sum_q[axis_q] + (ok_q ? SUMW'(raw_q) : '0);
		last_att  = att_new == CAL_N;
		center_a  = center_q[axis_q];
		neg       = raw_q < center_a;
		span      = neg ? center_a : (ADC_MAX - center_a);
		diff      = neg ? (center_a - raw_q) : (raw_q - center_a);
		mag       = div_quo[DW-1:0];
		below_dz  = mag < {1'b0, dz_q};
		md        = mag - {1'b0, dz_q};
		cnew      = div_quo[SB-1:0];
		ctr_dist  = (cnew >= ADC_MID) ? (cnew - ADC_MID) : (ADC_MID - cnew);
		in_limit  = CMPW'(ctr_dist) <= CMPW'(lim_q);
		scaled    = div_quo[DZ_W-1] ? {1'b0, {(DZ_W-1){1'b1}}} : div_quo[DZ_W-1:0];
		out_free  = !m_valid_q || m_tready;
	end

	// Select divider operands for the current step
	always_comb begin
		priority if (state_q == ST_DIV1) begin
			div_r0    = md >> 1;
			div_lo    = {md[0], {(LW-1){1'b0}}};
			div_dvs   = {1'b1, {DZ_W{1'b0}}} - {1'b0, dz_q};
			div_steps = STW'(DZ_W);
		end else if (!done_a) begin
			div_r0    = '0;
			div_lo    = LW'(sum_new) << (LW - SUMW);
			div_dvs   = DW'(good_new);
			div_steps = STW'(SUMW);
		end else begin
			div_r0    = DW'(diff >> 1);
			div_lo    = {diff[0], {(LW-1){1'b0}}};
			div_dvs   = DW'(span);
			div_steps = STW'(DW);
		end
	end

	// Next state and divider start
	always_comb begin
		state_nx  = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!done_a) begin
					if (last_att && good_new != '0) begin
						div_start = 1'b1;
						state_nx  = ST_CDIV;
					end else begin
						state_nx = ST_OUT;
					end
				end else if (both_done && ok_q && span != '0) begin
					div_start = 1'b1;
					state_nx  = ST_DIV1;
				end else begin
					state_nx = ST_OUT;
				end
			end
			ST_CDIV: begin
				if (div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					if (below_dz) begin
						state_nx = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_nx  = ST_DIV2;
					end
				end
			end
			ST_DIV2: begin
				if (div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q  <= DZ_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DZ_FRAC) begin
				dz_q <= cfg_data[DZ_W-1:0];
			end else if (cfg_index == REG_OFFSET_LIMIT) begin
				lim_q <= cfg_data[LIM_W-1:0];
			end
		end
	end

	// Advance calibration and set the center when an axis finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				center_q[i] <= ADC_MID;
				sum_q[i]    <= '0;
				att_q[i]    <= '0;
				good_q[i]   <= '0;
				fb_q[i]     <= 1'b0;
			end
		end else if (state_q == ST_EVAL && !done_a) begin
			att_q[axis_q]  <= att_new;
			good_q[axis_q] <= good_new;
			sum_q[axis_q]  <= sum_new;
			if (last_att && good_new == '0) begin
				center_q[axis_q] <= ADC_MID;
				fb_q[axis_q]     <= 1'b0;
			end
		end else if (state_q == ST_CDIV && div_done) begin
			center_q[axis_q] <= in_limit ? cnew : ADC_MID;
			fb_q[axis_q]     <= !in_limit;
		end
	end

	// Hold the item in flight and build the position
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			axis_q <= s_tuser[0];
			ok_q   <= s_tuser[1];
			raw_q  <= SB'(s_tdata[SAMPLE_W-1:0]);
		end
		if (state_q == ST_EVAL) begin
			pos_q <= '0;
			neg_q <= neg;
		end else if (state_q == ST_DIV2 && div_done) begin
			pos_q <= neg_q ? (POS_W'(0) - scaled) : scaled;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= pos_q;
			m_user_q <= {fb_q[axis_q], both_done, axis_q};
		end
	end

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_user_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import jacd_pkg::*; ();

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int TAIL_CYCLES     = 40;
	localparam int CALIB_ATTEMPTS  = CALIB_COUNT_DEF;
	localparam int PHASE_ITEMS     = 217;

	localparam logic [SAMPLE_W-1:0] ADC_FULL = {SAMPLE_W{1'b1}};
	localparam logic [SAMPLE_W-1:0] ADC_MID  = ADC_FULL >> 1;

	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_OFFSET_LIMIT + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = {CFG_IDX_W{1'b1}};

	// Calibration plans for the Y axis
	localparam int PLAN_FAR_CENTER  = 0;
	localparam int PLAN_FULL_SCALE  = 1;
	localparam int PLAN_NEAR_TARGET = 2;

	typedef struct packed {
		logic                 axis;
		logic [POS_W-1:0]     position;
		logic                 ready;
		logic                 fallback;
	} stick_result_t;

	// Tracks calibration and dead zone state, predicts and checks each result
	class stick_tracker;
		logic [DZ_W-1:0]     dz_frac;
		logic [LIM_W-1:0]    offset_limit;
		logic [SAMPLE_W-1:0] center[2];
		int unsigned         sum_acc[2];
		int unsigned         tries[2];
		int unsigned         goods[2];
		logic                fallback[2];
		stick_result_t       expected_q[$];
		int                  errors;

		function new();
			dz_frac      = DZ_RESET;
			offset_limit = LIM_RESET;
			errors       = 0;
			for (int a = 0; a < 2; a++) begin
				center[a]   = ADC_MID;
				sum_acc[a]  = 0;
				tries[a]    = 0;
				goods[a]    = 0;
				fallback[a] = 1'b0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			if (idx == REG_DZ_FRAC) begin
				dz_frac = val[DZ_W-1:0];
			end else if (idx == REG_OFFSET_LIMIT) begin
				offset_limit = val[LIM_W-1:0];
			end
		endfunction

		function bit axis_done(int a);
			return tries[a] >= CALIB_ATTEMPTS;
		endfunction

		// Average the good attempts, fall back to mid-scale when too far off
		function void close_calibration(int a);
			int unsigned c;
			int unsigned offset;
			c = (goods[a] != 0) ? sum_acc[a] / goods[a] : ADC_MID;
			offset = (c >= ADC_MID) ? c - ADC_MID : ADC_MID - c;
			if (offset <= offset_limit) begin
				center[a]   = c[SAMPLE_W-1:0];
				fallback[a] = 1'b0;
			end else begin
				center[a]   = ADC_MID;
				fallback[a] = 1'b1;
			end
		endfunction

		// Scale by the side span, cut the dead zone, stretch the rest to Q1.15
		function logic [POS_W-1:0] deflection(logic [SAMPLE_W-1:0] raw,
				logic [SAMPLE_W-1:0] ctr);
			logic            below;
			longint unsigned span;
			longint unsigned diff;
			longint unsigned mag;
			longint unsigned scaled;
			longint unsigned dz;
			below = raw < ctr;
			span  = below ? ctr : ADC_FULL - ctr;
			diff  = below ? ctr - raw : raw - ctr;
			dz    = dz_frac;
			if (span == 0)
				return '0;
			mag = (diff << 16) / span;
			if (mag > 65536)
				mag = 65536;
			if (mag < dz)
				return '0;
			scaled = ((mag - dz) << 15) / (65536 - dz);
			if (scaled > 32767)
				scaled = 32767;
			return below ? POS_W'(0 - scaled) : POS_W'(scaled);
		endfunction

		function void note_sample(logic ax, logic [SAMPLE_W-1:0] smp, logic ok);
			stick_result_t r;
			int            a;
			r = '0;
			a = ax;
			if (!axis_done(a)) begin
				tries[a]++;
				if (ok) begin
					sum_acc[a] += smp;
					goods[a]++;
				end
				if (axis_done(a))
					close_calibration(a);
				r.ready = axis_done(0) && axis_done(1);
			end else begin
				r.ready = axis_done(0) && axis_done(1);
				if (r.ready && ok)
					r.position = deflection(smp, center[a]);
			end
			r.axis     = ax;
			r.fallback = fallback[a];
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_result(input logic [POS_W-1:0] pos, input logic [M_USER_W-1:0] user);
			stick_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected transaction pos=%0d user=%b",
					$signed(pos), user));
				return;
			end
			e = expected_q.pop_front();
			if (user[0] !== e.axis)
				report($sformatf("axis_out %b, expected %b", user[0], e.axis));
			if (pos !== e.position)
				report($sformatf("position %0d, expected %0d (axis %b)",
					$signed(pos), $signed(e.position), e.axis));
			if (user[1] !== e.ready)
				report($sformatf("ready_res %b, expected %b (axis %b)",
					user[1], e.ready, e.axis));
			if (user[2] !== e.fallback)
				report($sformatf("center_fallback %b, expected %b (axis %b)",
					user[2], e.fallback, e.axis));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [S_USER_W-1:0]   s_tuser = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [POS_W-1:0]      m_tdata;
	logic [M_USER_W-1:0]   m_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DAT_W-1:0]  cfg_data = '0;

	stick_tracker stick;
	bit           steady = 1'b0;

	joystick_axis_calibrate_deadzone i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none while steady
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Present one sample and hold it until the transaction completes
	task automatic send_sample(input logic ax, input logic [SAMPLE_W-1:0] smp,
			input logic ok);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {{(S_DATA_W - SAMPLE_W){1'b0}}, smp};
		s_tuser  = {ok, ax};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		stick.note_sample(ax, smp, ok);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (stick.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		stick.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One Y calibration attempt; the first one is always good
	task automatic send_y_calib(input int plan, input int target, input int idx);
		logic ok;
		int   v;
		ok = (idx == 0) || ($urandom_range(0, 3) != 0);
		if (!ok)
			v = $urandom_range(0, ADC_FULL);
		else if (plan == PLAN_FAR_CENTER)
			v = $urandom_range(3500, ADC_FULL);
		else if (plan == PLAN_FULL_SCALE)
			v = ADC_FULL;
		else
			v = target + int'($urandom_range(0, 600)) - 300;
		send_sample(1'b1, v[SAMPLE_W-1:0], ok);
	endtask

	// Directed points around the calibrated center of one axis
	task automatic send_center_points(input logic ax);
		logic [SAMPLE_W-1:0] c;
		c = stick.center[ax];
		send_sample(ax, '0, 1'b1);
		send_sample(ax, ADC_FULL, 1'b1);
		send_sample(ax, c, 1'b1);
		if (c != ADC_FULL)
			send_sample(ax, c + 1'b1, 1'b1);
		if (c != 0)
			send_sample(ax, c - 1'b1, 1'b1);
		send_sample(ax, ADC_FULL, 1'b0);
	endtask

	// Uniform samples mixed with values near the center and the rails
	task automatic send_random_item();
		logic                ax;
		logic                ok;
		logic [SAMPLE_W-1:0] c;
		int                  v;
		ax = $urandom_range(0, 1);
		ok = $urandom_range(0, 9) != 0;
		c  = stick.center[ax];
		case ($urandom_range(0, 3))
			1: begin
				v = int'(c) + int'($urandom_range(0, 128)) - 64;
				if (v < 0)
					v = 0;
				if (v > ADC_FULL)
					v = ADC_FULL;
			end
			2: begin
				case ($urandom_range(0, 2))
					0: v = 0;
					1: v = ADC_FULL;
					default: v = c;
				endcase
			end
			default: v = $urandom_range(0, ADC_FULL);
		endcase
		send_sample(ax, v[SAMPLE_W-1:0], ok);
	endtask

	// Stall the result side at random
	initial begin : result_stall
		int gap;
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			stick.check_result(m_tdata, m_tuser);
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL joystick_axis_calibrate_deadzone");
		$finish;
	end

	initial begin : stimulus
		int              y_plan;
		int              y_target;
		logic [DZ_W-1:0] dz_pick[6];
		stick = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Tightest offset limit for X, plus a write to an unused index
		write_cfg(REG_OFFSET_LIMIT, '0);
		write_cfg(REG_UNUSED_LO, CFG_DAT_W'($urandom));
		y_plan   = $urandom_range(PLAN_FAR_CENTER, PLAN_NEAR_TARGET);
		y_target = $urandom_range(600, 3500);

		// Start Y calibration, then run X through calibration on failed reads only
		for (int n = 0; n < 8; n++)
			send_y_calib(y_plan, y_target, n);
		for (int n = 0; n < CALIB_ATTEMPTS; n++)
			send_sample(1'b0, SAMPLE_W'($urandom_range(0, ADC_FULL)), 1'b0);

		// X calibrated, Y still calibrating: block not ready yet
		send_sample(1'b0, '0, 1'b1);
		send_sample(1'b0, ADC_FULL, 1'b1);

		// Limit for Y chosen to match its plan
		drain();
		if (y_plan == PLAN_FAR_CENTER)
			write_cfg(REG_OFFSET_LIMIT, CFG_DAT_W'($urandom_range(0, 1400)));
		else if (y_plan == PLAN_FULL_SCALE)
			write_cfg(REG_OFFSET_LIMIT, CFG_DAT_W'(ADC_FULL));
		else
			write_cfg(REG_OFFSET_LIMIT, CFG_DAT_W'($urandom_range(2100, ADC_FULL)));
		for (int n = 8; n < CALIB_ATTEMPTS; n++)
			send_y_calib(y_plan, y_target, n);

		// Directed deflections at reset dead zone, then both dead zone extremes
		send_center_points(1'b0);
		send_center_points(1'b1);
		drain();
		write_cfg(REG_DZ_FRAC, '0);
		for (int a = 0; a < 2; a++) begin
			send_sample(a[0], '0, 1'b1);
			send_sample(a[0], ADC_FULL, 1'b1);
		end
		drain();
		write_cfg(REG_DZ_FRAC, {CFG_DAT_W{1'b1}});
		for (int a = 0; a < 2; a++) begin
			send_sample(a[0], '0, 1'b1);
			send_sample(a[0], ADC_FULL, 1'b1);
			if (stick.center[a] != ADC_FULL)
				send_sample(a[0], stick.center[a] + 1'b1, 1'b1);
		end

		// Random phases, each under its own dead zone
		dz_pick[0] = '0;
		dz_pick[1] = {DZ_W{1'b1}};
		dz_pick[2] = DZ_RESET;
		dz_pick[3] = DZ_W'($urandom);
		dz_pick[4] = DZ_W'(1);
		dz_pick[5] = {DZ_W{1'b1}} - 1'b1;
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			write_cfg(REG_DZ_FRAC, dz_pick[phase]);
			if (phase % 2 == 1)
				write_cfg(REG_OFFSET_LIMIT, CFG_DAT_W'($urandom_range(0, ADC_FULL)));
			if (phase == 3)
				write_cfg(REG_UNUSED_HI, CFG_DAT_W'($urandom));
			steady = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_item();
		end

		// Let the last results arrive, then a short tail
		drain();
		steady = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stick.pending() != 0)
			stick.report($sformatf("%0d results never arrived", stick.pending()));
		if (stick.errors == 0) begin
			$display("PASS joystick_axis_calibrate_deadzone");
		end else begin
			$display("FAIL joystick_axis_calibrate_deadzone");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/jacd_pkg.sv
sv/jacd_div.sv
sv/joystick_axis_calibrate_deadzone.sv
tb/sv/tb_top.sv
